### hw/rtl/dcst_pkg.sv
// Shared types and constants for the dirty cell strip tracker.
package dcst_pkg;

  localparam int PIX_W = 10;
  localparam logic [PIX_W-1:0] PIX_MAX = 10'd1023;
  localparam int DIV_SHIFT = 16;
  localparam int MUL_A_W = 10;
  localparam int MUL_B_W = 17;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [1:0] {
    CMD_MARK  = 2'd0,
    CMD_FULL  = 2'd1,
    CMD_SCAN  = 2'd2,
    CMD_END   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_STRIP = 2'd1,
    KIND_FULL  = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    REG_GRID_COLUMNS  = 3'd0,
    REG_GRID_ROWS     = 3'd1,
    REG_SCREEN_WIDTH  = 3'd2,
    REG_SCREEN_HEIGHT = 3'd3,
    REG_MENU_HEIGHT   = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [6:0] grid_columns;
    logic [4:0] grid_rows;
    logic [9:0] screen_width;
    logic [9:0] screen_height;
    logic [8:0] menu_height;
  } cfg_t;

  typedef struct packed {
    kind_t      kind;
    logic [9:0] x;
    logic [9:0] y;
    logic [9:0] width;
    logic [9:0] height;
    logic       last;
  } res_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV_A,
    ST_DIV_B,
    ST_DIV_C,
    ST_CLAMP,
    ST_MARK_RD,
    ST_MARK_WR,
    ST_SCAN_RD,
    ST_SCAN_CAP,
    ST_SCAN_WALK,
    ST_AGE_RD,
    ST_AGE_WR
  } state_t;

endpackage

### hw/rtl/dcst_ram.sv
// Generic single-write, single-read RAM with registered read data.
module dcst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### hw/rtl/dcst_mul.sv
// Shared registered multiplier used for cell index division and row pixel offset.
module dcst_mul
  import dcst_pkg::*;
(
  input  logic               clk,
  input  logic [MUL_A_W-1:0] a,
  input  logic [MUL_B_W-1:0] b,
  output logic [MUL_P_W-1:0] p
);

  logic [MUL_P_W-1:0] p_r;

  always_ff @(posedge clk) begin
    p_r <= MUL_P_W'(a) * MUL_P_W'(b);
  end

  assign p = p_r;

endmodule

### hw/rtl/dcst_regs.sv
// APB configuration register file for the dirty cell strip tracker.
module dcst_regs
  import dcst_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  reg_idx_t idx;
  logic     wr;

  always_comb begin
    idx     = reg_idx_t'(paddr[4:2]);
    wr      = psel && penable && pwrite;
    cfg_nxt = cfg_r;
    prdata  = '0;
    case (idx)
      REG_GRID_COLUMNS: begin
        prdata = CFG_DATA_W'(cfg_r.grid_columns);
        if (wr) cfg_nxt.grid_columns = pwdata[6:0];
      end
      REG_GRID_ROWS: begin
        prdata = CFG_DATA_W'(cfg_r.grid_rows);
        if (wr) cfg_nxt.grid_rows = pwdata[4:0];
      end
      REG_SCREEN_WIDTH: begin
        prdata = CFG_DATA_W'(cfg_r.screen_width);
        if (wr) cfg_nxt.screen_width = pwdata[9:0];
      end
      REG_SCREEN_HEIGHT: begin
        prdata = CFG_DATA_W'(cfg_r.screen_height);
        if (wr) cfg_nxt.screen_height = pwdata[9:0];
      end
      REG_MENU_HEIGHT: begin
        prdata = CFG_DATA_W'(cfg_r.menu_height);
        if (wr) cfg_nxt.menu_height = pwdata[8:0];
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.grid_columns  <= 7'd64;
      cfg_r.grid_rows     <= 5'd24;
      cfg_r.screen_width  <= 10'd640;
      cfg_r.screen_height <= 10'd480;
      cfg_r.menu_height   <= 9'd40;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign pready = 1'b1;
  assign cfg    = cfg_r;

endmodule

### hw/rtl/dirty_cell_strip_tracker.sv
// Top level of the dirty cell strip tracker: sequencer, row memory and result register.
//
// A request is taken when start is high and busy is low; busy then stays high while the
// sequencer works. Mark rectangle divides out four cell indices on the shared multiplier
// (reciprocal product, then a correction product), then, unless the rectangle is
// inverted, reads and writes back each covered cell row through the row memory. Request
// full redraw sets the pending flag and leaves busy low. Scan row reads the row,
// captures it and then walks the columns in use, one cell per cycle; an empty row ends
// after the capture, and a scan while a full redraw is pending or of a row out of range
// is answered from idle without raising busy. End frame reads and writes back every
// stored row to age it. Each result stands for exactly one cycle on out_valid with no
// way to hold it off; the receiver must take it then. Row memory needs no clearing pass
// after reset: one valid flag per row, cleared at reset, makes an unwritten row read as
// empty.
module dirty_cell_strip_tracker
  import dcst_pkg::*;
#(
  parameter int CELL_WIDTH  = 10,
  parameter int CELL_HEIGHT = 20,
  parameter int MAX_COLUMNS = 64,
  parameter int MAX_ROWS    = 24
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            in_command,
  input  logic [9:0]            in_left,
  input  logic [9:0]            in_top,
  input  logic [9:0]            in_right,
  input  logic [9:0]            in_bottom,
  input  logic [4:0]            in_row,
  output logic                  out_valid,
  output logic [1:0]            out_kind,
  output logic [9:0]            out_x,
  output logic [9:0]            out_y,
  output logic [9:0]            out_width,
  output logic [9:0]            out_height,
  output logic                  out_last,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int COL_W    = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int ROW_W    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int ROW_BITS = 2 * MAX_COLUMNS;
  localparam int ACC_RAW  = $clog2((MAX_COLUMNS + 2) * CELL_WIDTH + 1);
  localparam int ACC_W    = (ACC_RAW > 11) ? ACC_RAW : 11;
  localparam int RECIP_CW = (1 << DIV_SHIFT) / CELL_WIDTH;
  localparam int RECIP_CH = (1 << DIV_SHIFT) / CELL_HEIGHT;

  cfg_t cfg;

  state_t state_r, state_nxt;

  logic [9:0]          l_r, l_nxt, t_r, t_nxt, rt_r, rt_nxt, b_r, b_nxt;
  logic [1:0]          k_r, k_nxt;
  logic [9:0]          qe_r, qe_nxt;
  logic [3:0][9:0]     q_r, q_nxt;
  logic [COL_W-1:0]    cx0_r, cx0_nxt, cx1_r, cx1_nxt;
  logic [ROW_W-1:0]    cy1_r, cy1_nxt, cur_row_r, cur_row_nxt;
  logic [MAX_ROWS-1:0] rvalid_r, rvalid_nxt;
  logic                pending_r, pending_nxt;
  logic [COL_W:0]      col_r, col_nxt;
  logic [MAX_COLUMNS-1:0] nz_r, nz_nxt, nz_cap;
  logic [ACC_W-1:0]    pix_r, pix_nxt, xs_r, xs_nxt;
  logic                in_run_r, in_run_nxt;
  logic [9:0]          y_r, y_nxt;
  logic                out_valid_r, out_valid_nxt;
  res_t                res_r, res_nxt;

  logic [MUL_A_W-1:0]  mul_a;
  logic [MUL_B_W-1:0]  mul_b;
  logic [MUL_P_W-1:0]  mul_p;

  logic                ram_we;
  logic [ROW_BITS-1:0] ram_wdata, ram_rdata;
  logic [ROW_BITS-1:0] row_word, mark_word, age_word;

  logic [6:0]          cols7, rows7;
  logic [COL_W-1:0]    cols_m1;
  logic [COL_W:0]      cols_c;
  logic [ROW_W-1:0]    rows_m1;
  logic                row_oor;
  logic [9:0]          x_k;
  logic [MUL_B_W-1:0]  div_c, recip_k;
  logic [10:0]         rem;
  logic [9:0]          q_fix;
  logic                inverted;
  logic [9:0]          menu_twice, full_h, y_sat;

  function automatic logic [9:0] sat_acc(input logic [ACC_W-1:0] v);
    return (v > ACC_W'(PIX_MAX)) ? PIX_MAX : v[9:0];
  endfunction

  dcst_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  dcst_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  dcst_ram #(
    .WIDTH (ROW_BITS),
    .DEPTH (MAX_ROWS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cur_row_r),
    .wdata (ram_wdata),
    .raddr (cur_row_r),
    .rdata (ram_rdata)
  );

  always_comb begin
    if (cfg.grid_columns == 7'd0) begin
      cols7 = 7'd1;
    end else if (cfg.grid_columns > 7'(MAX_COLUMNS)) begin
      cols7 = 7'(MAX_COLUMNS);
    end else begin
      cols7 = cfg.grid_columns;
    end
    if (cfg.grid_rows == 5'd0) begin
      rows7 = 7'd1;
    end else if (7'(cfg.grid_rows) > 7'(MAX_ROWS)) begin
      rows7 = 7'(MAX_ROWS);
    end else begin
      rows7 = 7'(cfg.grid_rows);
    end
    cols_m1 = COL_W'(cols7 - 7'd1);
    cols_c  = (COL_W + 1)'(cols7);
    rows_m1 = ROW_W'(rows7 - 7'd1);
    row_oor = 7'(in_row) >= rows7;

    case (k_r)
      2'd0:    x_k = l_r;
      2'd1:    x_k = rt_r;
      2'd2:    x_k = t_r;
      default: x_k = b_r;
    endcase
    div_c   = k_r[1] ? MUL_B_W'(CELL_HEIGHT) : MUL_B_W'(CELL_WIDTH);
    recip_k = k_r[1] ? MUL_B_W'(RECIP_CH) : MUL_B_W'(RECIP_CW);
    rem     = {1'b0, x_k} - mul_p[10:0];
    q_fix   = (rem >= div_c[10:0]) ? qe_r + 10'd1 : qe_r;

    inverted = (q_r[0] > q_r[1]) || (q_r[2] > q_r[3]);

    menu_twice = {cfg.menu_height, 1'b0};
    full_h     = (cfg.screen_height > menu_twice) ? cfg.screen_height - menu_twice : 10'd0;
    y_sat      = (mul_p > MUL_P_W'(PIX_MAX)) ? PIX_MAX : mul_p[9:0];

    row_word  = rvalid_r[cur_row_r] ? ram_rdata : '0;
    mark_word = row_word;
    for (int j = 0; j < MAX_COLUMNS; j++) begin
      if ((COL_W'(j) >= cx0_r) && (COL_W'(j) <= cx1_r)) begin
        mark_word[2*j +: 2] = 2'b10;
      end
      age_word[2*j +: 2] = {1'b0, row_word[2*j+1]};
      nz_cap[j] = (|row_word[2*j +: 2]) && ((COL_W + 1)'(j) < cols_c);
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          case (in_command)
            CMD_MARK: state_nxt = ST_DIV_A;
            CMD_SCAN: state_nxt = (pending_r || row_oor) ? ST_IDLE : ST_SCAN_RD;
            CMD_END:  state_nxt = ST_AGE_RD;
            default:  state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_DIV_A:     state_nxt = ST_DIV_B;
      ST_DIV_B:     state_nxt = ST_DIV_C;
      ST_DIV_C:     state_nxt = (k_r == 2'd3) ? ST_CLAMP : ST_DIV_A;
      ST_CLAMP:     state_nxt = inverted ? ST_IDLE : ST_MARK_RD;
      ST_MARK_RD:   state_nxt = ST_MARK_WR;
      ST_MARK_WR:   state_nxt = (cur_row_r == cy1_r) ? ST_IDLE : ST_MARK_RD;
      ST_SCAN_RD:   state_nxt = ST_SCAN_CAP;
      ST_SCAN_CAP:  state_nxt = (nz_cap == '0) ? ST_IDLE : ST_SCAN_WALK;
      ST_SCAN_WALK: state_nxt = (col_r == cols_c) ? ST_IDLE : ST_SCAN_WALK;
      ST_AGE_RD:    state_nxt = ST_AGE_WR;
      ST_AGE_WR:    state_nxt = (cur_row_r == ROW_W'(MAX_ROWS - 1)) ? ST_IDLE : ST_AGE_RD;
      default:      state_nxt = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    l_nxt         = l_r;
    t_nxt         = t_r;
    rt_nxt        = rt_r;
    b_nxt         = b_r;
    k_nxt         = k_r;
    qe_nxt        = qe_r;
    q_nxt         = q_r;
    cx0_nxt       = cx0_r;
    cx1_nxt       = cx1_r;
    cy1_nxt       = cy1_r;
    cur_row_nxt   = cur_row_r;
    rvalid_nxt    = rvalid_r;
    pending_nxt   = pending_r;
    col_nxt       = col_r;
    nz_nxt        = nz_r;
    pix_nxt       = pix_r;
    xs_nxt        = xs_r;
    in_run_nxt    = in_run_r;
    y_nxt         = y_r;
    out_valid_nxt = 1'b0;
    res_nxt       = res_r;
    mul_a         = x_k;
    mul_b         = recip_k;
    ram_we        = 1'b0;
    ram_wdata     = mark_word;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          l_nxt  = in_left;
          t_nxt  = in_top;
          rt_nxt = in_right;
          b_nxt  = in_bottom;
          k_nxt  = 2'd0;
          case (in_command)
            CMD_FULL: begin
              pending_nxt = 1'b1;
            end
            CMD_SCAN: begin
              cur_row_nxt = ROW_W'(in_row);
              if (pending_r || row_oor) begin
                out_valid_nxt = 1'b1;
                res_nxt       = '{KIND_NONE, 10'd0, 10'd0, 10'd0, 10'd0, 1'b1};
              end
            end
            CMD_END: begin
              cur_row_nxt   = '0;
              out_valid_nxt = 1'b1;
              if (pending_r) begin
                pending_nxt = 1'b0;
                res_nxt     = '{KIND_FULL, 10'd0, 10'(cfg.menu_height),
                                cfg.screen_width, full_h, 1'b1};
              end else begin
                res_nxt = '{KIND_NONE, 10'd0, 10'd0, 10'd0, 10'd0, 1'b1};
              end
            end
            default: begin
              k_nxt = 2'd0;
            end
          endcase
        end
      end
      ST_DIV_B: begin
        qe_nxt = mul_p[DIV_SHIFT +: 10];
        mul_a  = mul_p[DIV_SHIFT +: 10];
        mul_b  = div_c;
      end
      ST_DIV_C: begin
        q_nxt[k_r] = q_fix;
        k_nxt      = k_r + 2'd1;
      end
      ST_CLAMP: begin
        cx0_nxt     = (q_r[0] > 10'(cols_m1)) ? cols_m1 : COL_W'(q_r[0]);
        cx1_nxt     = (q_r[1] > 10'(cols_m1)) ? cols_m1 : COL_W'(q_r[1]);
        cur_row_nxt = (q_r[2] > 10'(rows_m1)) ? rows_m1 : ROW_W'(q_r[2]);
        cy1_nxt     = (q_r[3] > 10'(rows_m1)) ? rows_m1 : ROW_W'(q_r[3]);
      end
      ST_MARK_WR: begin
        ram_we                = 1'b1;
        ram_wdata             = mark_word;
        rvalid_nxt[cur_row_r] = 1'b1;
        cur_row_nxt           = cur_row_r + ROW_W'(1);
      end
      ST_SCAN_RD: begin
        mul_a = MUL_A_W'(cur_row_r);
        mul_b = MUL_B_W'(CELL_HEIGHT);
      end
      ST_SCAN_CAP: begin
        y_nxt      = y_sat;
        nz_nxt     = nz_cap;
        col_nxt    = '0;
        pix_nxt    = '0;
        in_run_nxt = 1'b0;
        if (nz_cap == '0) begin
          out_valid_nxt = 1'b1;
          res_nxt       = '{KIND_NONE, 10'd0, 10'd0, 10'd0, 10'd0, 1'b1};
        end
      end
      ST_SCAN_WALK: begin
        if (nz_r[0]) begin
          if (!in_run_r) begin
            xs_nxt     = pix_r;
            in_run_nxt = 1'b1;
          end
        end else if (in_run_r) begin
          out_valid_nxt = 1'b1;
          res_nxt       = '{KIND_STRIP, sat_acc(xs_r), y_r, sat_acc(pix_r - xs_r),
                            10'(CELL_HEIGHT), ~|nz_r};
          in_run_nxt    = 1'b0;
        end
        nz_nxt  = nz_r >> 1;
        pix_nxt = pix_r + ACC_W'(CELL_WIDTH);
        col_nxt = col_r + (COL_W + 1)'(1);
      end
      ST_AGE_WR: begin
        ram_we                = 1'b1;
        ram_wdata             = age_word;
        rvalid_nxt[cur_row_r] = 1'b1;
        cur_row_nxt           = cur_row_r + ROW_W'(1);
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rvalid_r    <= '0;
      pending_r   <= 1'b1;
      out_valid_r <= 1'b0;
      k_r         <= 2'd0;
      in_run_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rvalid_r    <= rvalid_nxt;
      pending_r   <= pending_nxt;
      out_valid_r <= out_valid_nxt;
      k_r         <= k_nxt;
      in_run_r    <= in_run_nxt;
    end
  end

  always_ff @(posedge clk) begin
    l_r       <= l_nxt;
    t_r       <= t_nxt;
    rt_r      <= rt_nxt;
    b_r       <= b_nxt;
    qe_r      <= qe_nxt;
    q_r       <= q_nxt;
    cx0_r     <= cx0_nxt;
    cx1_r     <= cx1_nxt;
    cy1_r     <= cy1_nxt;
    cur_row_r <= cur_row_nxt;
    col_r     <= col_nxt;
    nz_r      <= nz_nxt;
    pix_r     <= pix_nxt;
    xs_r      <= xs_nxt;
    y_r       <= y_nxt;
    res_r     <= res_nxt;
  end

  assign busy       = (state_r != ST_IDLE);
  assign out_valid  = out_valid_r;
  assign out_kind   = res_r.kind;
  assign out_x      = res_r.x;
  assign out_y      = res_r.y;
  assign out_width  = res_r.width;
  assign out_height = res_r.height;
  assign out_last   = res_r.last;

`ifndef SYNTHESIS
  a_end_full: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_command == CMD_END && pending_r
      |=> out_valid && out_kind == KIND_FULL && out_last && !pending_r)
    else $error("end frame with full redraw pending did not report the full area");

  a_scan_pending: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_command == CMD_SCAN && pending_r
      |=> out_valid && out_kind == KIND_NONE && out_last && !busy)
    else $error("scan during pending full redraw did not report nothing to copy");

  a_strip_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_STRIP |-> !pending_r && out_width != 10'd0)
    else $error("strip reported while full redraw pending or with zero width");

  a_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> busy)
    else $error("non-final result with sequencer idle");
`endif

endmodule

### test/tb_dirty_cell_strip_tracker.sv
`timescale 1ns / 1ps
// Self-checking testbench for the dirty cell strip tracker.
module tb_dirty_cell_strip_tracker;
  import dcst_pkg::*;

  localparam int CELL_WIDTH    = 10;
  localparam int CELL_HEIGHT   = 20;
  localparam int MAX_COLUMNS   = 64;
  localparam int MAX_ROWS      = 24;
  localparam int SETTLE_CYCLES = 80;
  localparam int IDLE_PERCENT  = 38;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  logic [1:0]            in_command;
  logic [9:0]            in_left;
  logic [9:0]            in_top;
  logic [9:0]            in_right;
  logic [9:0]            in_bottom;
  logic [4:0]            in_row;
  logic                  out_valid;
  logic [1:0]            out_kind;
  logic [9:0]            out_x;
  logic [9:0]            out_y;
  logic [9:0]            out_width;
  logic [9:0]            out_height;
  logic                  out_last;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  res_t       expected_copies[$];
  logic [1:0] shadow_age [MAX_ROWS][MAX_COLUMNS];
  bit         redraw_due;
  cfg_t       cfg_shadow;
  int         fail_count;
  bit         sender_idles;

  dirty_cell_strip_tracker #(
    .CELL_WIDTH (CELL_WIDTH),
    .CELL_HEIGHT(CELL_HEIGHT),
    .MAX_COLUMNS(MAX_COLUMNS),
    .MAX_ROWS   (MAX_ROWS)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_command(in_command),
    .in_left   (in_left),
    .in_top    (in_top),
    .in_right  (in_right),
    .in_bottom (in_bottom),
    .in_row    (in_row),
    .out_valid (out_valid),
    .out_kind  (out_kind),
    .out_x     (out_x),
    .out_y     (out_y),
    .out_width (out_width),
    .out_height(out_height),
    .out_last  (out_last),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always #1 clk = ~clk;

  task automatic report_mismatch(string msg);
    fail_count++;
    if (fail_count <= 100) $display("mismatch at %0t: %s", $time, msg);
  endtask

  function automatic int cols_in_use();
    if (cfg_shadow.grid_columns < 1) return 1;
    if (cfg_shadow.grid_columns > MAX_COLUMNS) return MAX_COLUMNS;
    return int'(cfg_shadow.grid_columns);
  endfunction

  function automatic int rows_in_use();
    if (cfg_shadow.grid_rows < 1) return 1;
    if (cfg_shadow.grid_rows > MAX_ROWS) return MAX_ROWS;
    return int'(cfg_shadow.grid_rows);
  endfunction

  function automatic logic [9:0] clip_pix(int v);
    return (v > 1023) ? PIX_MAX : v[9:0];
  endfunction

  function automatic void push_copy(kind_t k, int x, int y, int w, int h);
    res_t c;
    c.kind   = k;
    c.x      = clip_pix(x);
    c.y      = clip_pix(y);
    c.width  = clip_pix(w);
    c.height = clip_pix(h);
    c.last   = 1'b0;
    expected_copies.push_back(c);
  endfunction

  // Advance the shadow grid by one request and queue the areas it should report.
  function automatic void predict_copies(cmd_t cmd, logic [9:0] l, logic [9:0] t,
                                         logic [9:0] r, logic [9:0] b, logic [4:0] row);
    int   cols, rows, cx0, cx1, cy0, cy1, run, n, twice, h, i, j;
    res_t tail;
    cols = cols_in_use();
    rows = rows_in_use();
    n    = expected_copies.size();
    case (cmd)
      CMD_MARK: begin
        cx0 = l / CELL_WIDTH;
        cx1 = r / CELL_WIDTH;
        cy0 = t / CELL_HEIGHT;
        cy1 = b / CELL_HEIGHT;
        if (cx0 <= cx1 && cy0 <= cy1) begin
          if (cx0 > cols - 1) cx0 = cols - 1;
          if (cx1 > cols - 1) cx1 = cols - 1;
          if (cy0 > rows - 1) cy0 = rows - 1;
          if (cy1 > rows - 1) cy1 = rows - 1;
          for (i = cy0; i <= cy1; i++)
            for (j = cx0; j <= cx1; j++) shadow_age[i][j] = 2'd2;
        end
      end
      CMD_FULL: redraw_due = 1'b1;
      CMD_SCAN: begin
        if (!redraw_due && row < rows) begin
          run = 0;
          for (j = 0; j <= cols; j++) begin
            if (j < cols && shadow_age[row][j] != 2'd0) begin
              run++;
            end else if (run != 0) begin
              push_copy(KIND_STRIP, CELL_WIDTH * (j - run), CELL_HEIGHT * int'(row),
                        CELL_WIDTH * run, CELL_HEIGHT);
              run = 0;
            end
          end
        end
      end
      CMD_END: begin
        if (redraw_due) begin
          twice = 2 * int'(cfg_shadow.menu_height);
          h     = (int'(cfg_shadow.screen_height) > twice) ?
                  int'(cfg_shadow.screen_height) - twice : 0;
          push_copy(KIND_FULL, 0, int'(cfg_shadow.menu_height),
                    int'(cfg_shadow.screen_width), h);
          redraw_due = 1'b0;
        end
        for (i = 0; i < MAX_ROWS; i++)
          for (j = 0; j < MAX_COLUMNS; j++) shadow_age[i][j] = shadow_age[i][j] >> 1;
      end
      default: begin
      end
    endcase
    if (cmd == CMD_SCAN || cmd == CMD_END) begin
      if (expected_copies.size() == n) push_copy(KIND_NONE, 0, 0, 0, 0);
      tail = expected_copies.pop_back();
      tail.last = 1'b1;
      expected_copies.push_back(tail);
    end
  endfunction

  always @(posedge clk) begin : check_copies
    res_t want;
    if (rst_n && out_valid) begin
      if (expected_copies.size() == 0) begin
        report_mismatch($sformatf("result kind %0d with nothing expected", out_kind));
      end else begin
        want = expected_copies.pop_front();
        if (out_kind !== want.kind)
          report_mismatch($sformatf("kind got %0d expected %0d", out_kind, want.kind));
        if (out_x !== want.x)
          report_mismatch($sformatf("x got %0d expected %0d", out_x, want.x));
        if (out_y !== want.y)
          report_mismatch($sformatf("y got %0d expected %0d", out_y, want.y));
        if (out_width !== want.width)
          report_mismatch($sformatf("width got %0d expected %0d", out_width, want.width));
        if (out_height !== want.height)
          report_mismatch($sformatf("height got %0d expected %0d", out_height, want.height));
        if (out_last !== want.last)
          report_mismatch($sformatf("last got %0d expected %0d", out_last, want.last));
      end
    end
  end

  // Entered and left at a falling edge.
  task automatic send_request(cmd_t cmd, logic [9:0] l, logic [9:0] t, logic [9:0] r,
                              logic [9:0] b, logic [4:0] row);
    while (sender_idles && $urandom_range(99) < IDLE_PERCENT) begin
      start = 1'b0;
      @(negedge clk);
    end
    start      = 1'b1;
    in_command = cmd;
    in_left    = l;
    in_top     = t;
    in_right   = r;
    in_bottom  = b;
    in_row     = row;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_copies(cmd, l, t, r, b, row);
    @(negedge clk);
    start = 1'b0;
  endtask

  task automatic send_random_request();
    int         pick, cols, rows, cx0, cy0;
    logic [9:0] l, t, r, b;
    logic [4:0] row;
    cols = cols_in_use();
    rows = rows_in_use();
    l    = 10'($urandom_range(1023));
    t    = 10'($urandom_range(1023));
    r    = 10'($urandom_range(1023));
    b    = 10'($urandom_range(1023));
    row  = 5'($urandom_range(31));
    pick = $urandom_range(99);
    if (pick < 40) begin
      if ($urandom_range(4) != 0) begin
        cx0 = $urandom_range(cols - 1);
        cy0 = $urandom_range(rows - 1);
        l = 10'(cx0 * CELL_WIDTH + $urandom_range(CELL_WIDTH - 1));
        r = 10'((cx0 + $urandom_range(3)) * CELL_WIDTH + $urandom_range(CELL_WIDTH - 1));
        t = 10'(cy0 * CELL_HEIGHT + $urandom_range(CELL_HEIGHT - 1));
        b = 10'((cy0 + $urandom_range(1)) * CELL_HEIGHT + $urandom_range(CELL_HEIGHT - 1));
      end
      send_request(CMD_MARK, l, t, r, b, row);
    end else if (pick < 45) begin
      send_request(CMD_FULL, l, t, r, b, row);
    end else if (pick < 80) begin
      if ($urandom_range(7) != 0) row = 5'($urandom_range(rows - 1));
      send_request(CMD_SCAN, l, t, r, b, row);
    end else begin
      send_request(CMD_END, l, t, r, b, row);
    end
  endtask

  task automatic wait_for_copies();
    while (expected_copies.size() != 0) @(negedge clk);
  endtask

  task automatic settle();
    wait_for_copies();
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_register(reg_idx_t idx, logic [31:0] value);
    logic [31:0] want;
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = CFG_ADDR_W'(idx * 4);
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      REG_GRID_COLUMNS: begin
        cfg_shadow.grid_columns = value[6:0];
        want = 32'(value[6:0]);
      end
      REG_GRID_ROWS: begin
        cfg_shadow.grid_rows = value[4:0];
        want = 32'(value[4:0]);
      end
      REG_SCREEN_WIDTH: begin
        cfg_shadow.screen_width = value[9:0];
        want = 32'(value[9:0]);
      end
      REG_SCREEN_HEIGHT: begin
        cfg_shadow.screen_height = value[9:0];
        want = 32'(value[9:0]);
      end
      default: begin
        cfg_shadow.menu_height = value[8:0];
        want = 32'(value[8:0]);
      end
    endcase
    @(negedge clk);
    penable = 1'b0;
    pwrite  = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== want)
      report_mismatch($sformatf("register %0d read %0d expected %0d", idx, prdata, want));
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  task automatic apply_grid(int cols, int rows, int sw, int sh, int menu);
    settle();
    write_register(REG_GRID_COLUMNS, cols);
    write_register(REG_GRID_ROWS, rows);
    write_register(REG_SCREEN_WIDTH, sw);
    write_register(REG_SCREEN_HEIGHT, sh);
    write_register(REG_MENU_HEIGHT, menu);
  endtask

  task automatic test_first_frame();
    send_request(CMD_SCAN, 10'd0, 10'd0, 10'd0, 10'd0, 5'd0);
    send_request(CMD_END, 10'd1023, 10'd1023, 10'd1023, 10'd1023, 5'd31);
    send_request(CMD_SCAN, 10'd0, 10'd0, 10'd0, 10'd0, 5'd0);
  endtask

  task automatic test_mark_edges();
    send_request(CMD_MARK, 10'd0, 10'd0, 10'd0, 10'd0, 5'd0);
    send_request(CMD_MARK, 10'd1023, 10'd1023, 10'd1023, 10'd1023, 5'd31);
    send_request(CMD_MARK, 10'd20, 10'd0, 10'd9, 10'd0, 5'd0);
    send_request(CMD_MARK, 10'd0, 10'd40, 10'd0, 10'd19, 5'd0);
    send_request(CMD_MARK, 10'd30, 10'd0, 10'd59, 10'd19, 5'd0);
    send_request(CMD_SCAN, 10'd0, 10'd0, 10'd0, 10'd0, 5'd0);
    send_request(CMD_SCAN, 10'd0, 10'd0, 10'd0, 10'd0, 5'd23);
    send_request(CMD_SCAN, 10'd0, 10'd0, 10'd0, 10'd0, 5'd24);
    send_request(CMD_SCAN, 10'd0, 10'd0, 10'd0, 10'd0, 5'd31);
    send_request(CMD_END, 10'd0, 10'd0, 10'd0, 10'd0, 5'd0);
    send_request(CMD_SCAN, 10'd0, 10'd0, 10'd0, 10'd0, 5'd0);
    send_request(CMD_END, 10'd0, 10'd0, 10'd0, 10'd0, 5'd0);
    send_request(CMD_SCAN, 10'd0, 10'd0, 10'd0, 10'd0, 5'd0);
    send_request(CMD_MARK, 10'd0, 10'd0, 10'd1023, 10'd1023, 5'd0);
    send_request(CMD_SCAN, 10'd0, 10'd0, 10'd0, 10'd0, 5'd12);
  endtask

  task automatic test_redraw_request();
    send_request(CMD_FULL, 10'd0, 10'd0, 10'd0, 10'd0, 5'd0);
    send_request(CMD_SCAN, 10'd0, 10'd0, 10'd0, 10'd0, 5'd12);
    send_request(CMD_END, 10'd0, 10'd0, 10'd0, 10'd0, 5'd0);
    send_request(CMD_SCAN, 10'd0, 10'd0, 10'd0, 10'd0, 5'd12);
    send_request(CMD_END, 10'd0, 10'd0, 10'd0, 10'd0, 5'd0);
  endtask

  task automatic test_random_traffic(int count);
    repeat (count) send_random_request();
  endtask

  task automatic test_pause_until_drained();
    repeat (5) send_random_request();
    wait_for_copies();
    repeat (5) send_random_request();
  endtask

  task automatic test_grid_extremes();
    apply_grid(0, 0, 1, 1, 511);
    send_request(CMD_FULL, 10'd0, 10'd0, 10'd0, 10'd0, 5'd0);
    send_request(CMD_END, 10'd0, 10'd0, 10'd0, 10'd0, 5'd0);
    test_random_traffic(15);
    apply_grid(127, 31, 1023, 1023, 0);
    send_request(CMD_FULL, 10'd0, 10'd0, 10'd0, 10'd0, 5'd0);
    send_request(CMD_END, 10'd0, 10'd0, 10'd0, 10'd0, 5'd0);
    test_random_traffic(10);
    apply_grid(13, 5, 0, 0, 300);
    send_request(CMD_FULL, 10'd0, 10'd0, 10'd0, 10'd0, 5'd0);
    send_request(CMD_END, 10'd0, 10'd0, 10'd0, 10'd0, 5'd0);
    test_random_traffic(10);
    apply_grid(64, 24, $urandom_range(1, 1023), $urandom_range(1, 1023), $urandom_range(511));
    send_request(CMD_FULL, 10'd0, 10'd0, 10'd0, 10'd0, 5'd0);
    send_request(CMD_END, 10'd0, 10'd0, 10'd0, 10'd0, 5'd0);
    test_random_traffic(15);
  endtask

  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin : run_tests
    int i, j;
    rst_n        = 1'b0;
    start        = 1'b0;
    in_command   = CMD_MARK;
    in_left      = '0;
    in_top       = '0;
    in_right     = '0;
    in_bottom    = '0;
    in_row       = '0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    fail_count   = 0;
    sender_idles = 1'b1;
    redraw_due   = 1'b1;
    cfg_shadow   = '{grid_columns: 7'd64, grid_rows: 5'd24, screen_width: 10'd640,
                     screen_height: 10'd480, menu_height: 9'd40};
    for (i = 0; i < MAX_ROWS; i++)
      for (j = 0; j < MAX_COLUMNS; j++) shadow_age[i][j] = 2'd0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_first_frame();
    test_mark_edges();
    test_redraw_request();
    sender_idles = 1'b0;
    test_random_traffic(20);
    sender_idles = 1'b1;
    test_random_traffic(20);
    test_pause_until_drained();
    test_grid_extremes();

    settle();
    if (expected_copies.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_copies.size()));
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
